@@ rtl/mono_page_framebuffer_draw_assert.svh @@
// Assertion macros shared by the framebuffer draw engine RTL.
// Each macro expands to one labeled concurrent assertion that reports with $error.
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_ASSERT_SVH

// Condition and consequence in the same cycle, off while reset is high.
`define MPFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition, off while reset is high.
`define MPFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mpfd_pkg.sv @@
// Shared constants, types and the paint function of the framebuffer draw engine.
// No dependencies; used by the top level.
`default_nettype none

package mpfd_pkg;

   localparam int StoreDepth = 1024;
   localparam int StoreAw    = 10;
   localparam int PageBits   = 3;
   localparam int PageRows   = 1 << PageBits;
   localparam int CoordW     = 12;

   localparam logic [2:0] CmdPlot      = 3'd0;
   localparam logic [2:0] CmdReadPix   = 3'd1;
   localparam logic [2:0] CmdFill      = 3'd2;
   localparam logic [2:0] CmdRoundFill = 3'd3;
   localparam logic [2:0] CmdFrame     = 3'd4;
   localparam logic [2:0] CmdReadByte  = 3'd5;

   localparam logic [1:0] ModeSet    = 2'd0;
   localparam logic [1:0] ModeClear  = 2'd1;
   localparam logic [1:0] ModeInvert = 2'd2;

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic [StoreAw-1:0]       store_addr_type;

   // Applies a pixel mask to one page byte; the unused mode code acts as set.
   function automatic logic [7:0] paint_byte(input logic [7:0] old_byte,
                                             input logic [7:0] mask,
                                             input logic [1:0] mode);
      logic [7:0] result;
      case (mode)
         ModeInvert: result = old_byte ^ mask;
         ModeClear:  result = old_byte & ~mask;
         default:    result = old_byte | mask;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mpfd_ifs.sv @@
// Command and result channel interfaces of the framebuffer draw engine.
// Plain valid/ready channels; no dependencies.
`default_nettype none

interface mpfd_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         cmd;
   logic signed [10:0] x_pos;
   logic signed [10:0] y_pos;
   logic [7:0]         box_width;
   logic [7:0]         box_height;
   logic [1:0]         paint_mode;
   logic [9:0]         byte_index;

   modport source (output valid, cmd, x_pos, y_pos, box_width, box_height, paint_mode,
                   byte_index, input ready);
   modport sink (input valid, cmd, x_pos, y_pos, box_width, box_height, paint_mode,
                 byte_index, output ready);
endinterface

interface mpfd_rsp_if;
   logic       valid;
   logic       ready;
   logic       pixel_value;
   logic [7:0] byte_value;

   modport source (output valid, pixel_value, byte_value, input ready);
   modport sink (input valid, pixel_value, byte_value, output ready);
endinterface

`default_nettype wire

@@ rtl/mono_page_framebuffer_draw.sv @@
// Top level of the monochrome page framebuffer draw engine.
// Depends on mpfd_pkg, mpfd_ifs (channels), mpfd_ram and the assertion macro header.
`default_nettype none

// Drawing engine over a 1024-byte monochrome framebuffer laid out in pages of eight
// rows (byte = page * SCREEN_W + x, bit = y mod 8). One command is worked at a time
// and every command returns exactly one result word. After reset the store is swept
// to zero, one byte per cycle, and no command is taken during that sweep. Drawing
// commands walk the clipped rectangle byte by byte through the single store memory:
// each cycle reads one page byte while the byte read the cycle before is written
// back. A finished result waits in an output register, so the next command is
// taken while the previous result is still unread.

`include "mono_page_framebuffer_draw_assert.svh"

module mono_page_framebuffer_draw #(
   parameter int SCREEN_W = 128,
   parameter int SCREEN_H = 64
) (
   input  logic       clock,
   input  logic       reset,
   mpfd_req_if.sink   req_bus,
   mpfd_rsp_if.source rsp_bus
);

   localparam int Pages  = (SCREEN_H + mpfd_pkg::PageRows - 1) / mpfd_pkg::PageRows;
   localparam int XW     = $clog2(SCREEN_W);
   localparam int PW     = (Pages > 1) ? $clog2(Pages) : 1;
   localparam int FawRaw = $clog2(Pages * SCREEN_W + 1);
   localparam int FAW    = (FawRaw > mpfd_pkg::StoreAw) ? FawRaw : mpfd_pkg::StoreAw + 1;
   localparam int CW     = mpfd_pkg::CoordW;
   localparam int PB     = mpfd_pkg::PageBits;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SETUP  = 3'd2;
   localparam logic [2:0] S_WALK   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_PEEK   = 3'd5;
   localparam logic [2:0] S_CAPT   = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   logic [2:0]                 state_ff, state_in;
   mpfd_pkg::store_addr_type   clr_cnt_ff, clr_cnt_in;

   logic [2:0]                 cmd_ff, cmd_in;
   logic signed [10:0]         x_ff, x_in;
   logic signed [10:0]         y_ff, y_in;
   logic [7:0]                 w_ff, w_in;
   logic [7:0]                 h_ff, h_in;
   logic [1:0]                 mode_ff, mode_in;
   mpfd_pkg::store_addr_type   idx_ff, idx_in;

   logic [XW-1:0]              col_ff, col_in;
   logic [XW-1:0]              col_end_ff, col_end_in;
   logic [PW-1:0]              page_ff, page_in;
   logic [PW-1:0]              page_start_ff, page_start_in;
   logic [PW-1:0]              page_end_ff, page_end_in;

   logic                       wr_pend_ff, wr_pend_in;
   mpfd_pkg::store_addr_type   wr_addr_ff, wr_addr_in;
   logic [7:0]                 wr_mask_ff, wr_mask_in;

   logic                       res_pix_ff, res_pix_in;
   logic [7:0]                 res_byte_ff, res_byte_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_pix_ff, rsp_pix_in;
   logic [7:0]                 rsp_byte_ff, rsp_byte_in;

   mpfd_pkg::coord_type xs, ys, w_ext, h_ext, x_last, y_bot, y_in0, y_in1;
   mpfd_pkg::coord_type col_lo, col_hi, row_lo, row_hi;
   mpfd_pkg::coord_type col_s, row_base;
   mpfd_pkg::coord_type a_lo, a_hi, b_lo, b_hi;
   logic                b_on;
   logic                shape_empty;
   logic                is_edge;
   logic [7:0]          mask;
   logic [FAW-1:0]      full_addr;
   logic                in_store;
   mpfd_pkg::store_addr_type walk_addr;

   logic                     ram_wr_en;
   mpfd_pkg::store_addr_type ram_wr_addr;
   logic [7:0]               ram_wr_data;
   logic                     ram_rd_en;
   mpfd_pkg::store_addr_type ram_rd_addr;
   logic [7:0]               ram_rd_data;

   // Shape geometry of the current command.
   assign xs     = mpfd_pkg::coord_type'(x_ff);
   assign ys     = mpfd_pkg::coord_type'(y_ff);
   assign w_ext  = mpfd_pkg::coord_type'({{(CW-8){1'b0}}, w_ff});
   assign h_ext  = mpfd_pkg::coord_type'({{(CW-8){1'b0}}, h_ff});
   assign x_last = xs + w_ext - mpfd_pkg::coord_type'(1);
   assign y_bot  = ys + h_ext - mpfd_pkg::coord_type'(1);
   assign y_in0  = ys + mpfd_pkg::coord_type'(1);
   assign y_in1  = ys + h_ext - mpfd_pkg::coord_type'(2);

   // Clip window of the shape on screen.
   assign col_lo = (xs < mpfd_pkg::coord_type'(0)) ? mpfd_pkg::coord_type'(0) : xs;
   assign col_hi = (x_last > mpfd_pkg::coord_type'(SCREEN_W - 1)) ?
                   mpfd_pkg::coord_type'(SCREEN_W - 1) : x_last;
   assign row_lo = (ys < mpfd_pkg::coord_type'(0)) ? mpfd_pkg::coord_type'(0) : ys;
   assign row_hi = (y_bot > mpfd_pkg::coord_type'(SCREEN_H - 1)) ?
                   mpfd_pkg::coord_type'(SCREEN_H - 1) : y_bot;
   assign shape_empty = (w_ff == 8'd0) || (h_ff == 8'd0) || (col_lo > col_hi) ||
                        (row_lo > row_hi);

   // Position of the byte being walked.
   assign col_s    = mpfd_pkg::coord_type'({{(CW-XW){1'b0}}, col_ff});
   assign row_base = mpfd_pkg::coord_type'({{(CW-PW-PB){1'b0}}, page_ff, {PB{1'b0}}});
   assign is_edge  = (col_s == xs) || (col_s == x_last);

   assign full_addr = FAW'(page_ff) * FAW'(SCREEN_W) + FAW'(col_ff);
   assign in_store  = full_addr < FAW'(mpfd_pkg::StoreDepth);
   assign walk_addr = full_addr[mpfd_pkg::StoreAw-1:0];

   // Each column is painted by up to two row runs. A frame column that lies in two
   // runs (a one pixel wide or one pixel high frame) gets both, so invert cancels.
   always_comb begin
      a_lo = ys;
      a_hi = y_bot;
      b_lo = ys;
      b_hi = y_bot;
      b_on = 1'b0;
      case (cmd_ff)
         mpfd_pkg::CmdRoundFill: begin
            if (is_edge) begin
               a_lo = y_in0;
               a_hi = y_in1;
            end
         end
         mpfd_pkg::CmdFrame: begin
            if (is_edge) begin
               a_lo = y_in0;
               a_hi = y_in1;
               b_lo = y_in0;
               b_hi = y_in1;
               b_on = (w_ff == 8'd1);
            end else begin
               a_lo = ys;
               a_hi = ys;
               b_lo = y_bot;
               b_hi = y_bot;
               b_on = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      mpfd_pkg::coord_type row_k;
      logic                in_a;
      logic                in_b;
      mask = '0;
      for (int k = 0; k < mpfd_pkg::PageRows; k++) begin
         row_k   = row_base | mpfd_pkg::coord_type'(k);
         in_a    = (row_k >= a_lo) && (row_k <= a_hi);
         in_b    = b_on && (row_k >= b_lo) && (row_k <= b_hi);
         mask[k] = (row_k < mpfd_pkg::coord_type'(SCREEN_H)) &&
                   ((mode_ff == mpfd_pkg::ModeInvert) ? (in_a ^ in_b) : (in_a | in_b));
      end
   end

   // Store ports: the sweep after reset, or the write-back of the byte read last cycle.
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = 8'd0;
      end else begin
         ram_wr_en   = wr_pend_ff;
         ram_wr_addr = wr_addr_ff;
         ram_wr_data = mpfd_pkg::paint_byte(ram_rd_data, wr_mask_ff, mode_ff);
      end

      ram_rd_en   = 1'b0;
      ram_rd_addr = walk_addr;
      if ((state_ff == S_WALK || state_ff == S_PEEK) && in_store) begin
         ram_rd_en = 1'b1;
      end
      if (state_ff == S_SETUP && cmd_ff == mpfd_pkg::CmdReadByte) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = idx_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      col_in        = col_ff;
      col_end_in    = col_end_ff;
      page_in       = page_ff;
      page_start_in = page_start_ff;
      page_end_in   = page_end_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = walk_addr;
      wr_mask_in    = mask;
      res_pix_in    = res_pix_ff;
      res_byte_in   = res_byte_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pix_in    = rsp_pix_ff;
      rsp_byte_in   = rsp_byte_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + mpfd_pkg::store_addr_type'(1);
            if (clr_cnt_ff == mpfd_pkg::store_addr_type'(mpfd_pkg::StoreDepth - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               cmd_in  = req_bus.cmd;
               x_in    = req_bus.x_pos;
               y_in    = req_bus.y_pos;
               mode_in = req_bus.paint_mode;
               idx_in  = req_bus.byte_index;
               // A single pixel is walked as a one by one rectangle.
               if (req_bus.cmd == mpfd_pkg::CmdPlot || req_bus.cmd == mpfd_pkg::CmdReadPix)
               begin
                  w_in = 8'd1;
                  h_in = 8'd1;
               end else begin
                  w_in = req_bus.box_width;
                  h_in = req_bus.box_height;
               end
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            res_pix_in    = 1'b0;
            res_byte_in   = 8'd0;
            col_in        = col_lo[XW-1:0];
            col_end_in    = col_hi[XW-1:0];
            page_in       = row_lo[PW+PB-1:PB];
            page_start_in = row_lo[PW+PB-1:PB];
            page_end_in   = row_hi[PW+PB-1:PB];
            case (cmd_ff)
               mpfd_pkg::CmdPlot,
               mpfd_pkg::CmdFill,
               mpfd_pkg::CmdRoundFill,
               mpfd_pkg::CmdFrame:    state_in = shape_empty ? S_FINISH : S_WALK;
               mpfd_pkg::CmdReadPix:  state_in = shape_empty ? S_FINISH : S_PEEK;
               mpfd_pkg::CmdReadByte: state_in = S_CAPT;
               default:               state_in = S_FINISH;
            endcase
         end
         S_WALK: begin
            wr_pend_in = in_store;
            if (page_ff == page_end_ff) begin
               page_in = page_start_ff;
               if (col_ff == col_end_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  col_in = col_ff + XW'(1);
               end
            end else begin
               page_in = page_ff + PW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_PEEK: begin
            state_in = in_store ? S_CAPT : S_FINISH;
         end
         S_CAPT: begin
            if (cmd_ff == mpfd_pkg::CmdReadByte) begin
               res_byte_in = ram_rd_data;
            end else begin
               res_pix_in = ram_rd_data[y_ff[PB-1:0]];
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = res_pix_ff;
               rsp_byte_in  = res_byte_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      col_ff        <= col_in;
      col_end_ff    <= col_end_in;
      page_ff       <= page_in;
      page_start_ff <= page_start_in;
      page_end_ff   <= page_end_in;
      wr_addr_ff    <= wr_addr_in;
      wr_mask_ff    <= wr_mask_in;
      res_pix_ff    <= res_pix_in;
      res_byte_ff   <= res_byte_in;
      rsp_pix_ff    <= rsp_pix_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   mpfd_ram #(
      .WIDTH (8),
      .DEPTH (mpfd_pkg::StoreDepth)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_value = rsp_pix_ff;
   assign rsp_bus.byte_value  = rsp_byte_ff;

   `MPFD_ASSERT_NOW(a_write_in_walk, clock, reset, wr_pend_ff, (state_ff == S_WALK || state_ff == S_DRAIN), "write-back pending outside a drawing pass")
   `MPFD_ASSERT_NEXT(a_accept_setup, clock, reset, req_bus.valid && req_bus.ready, state_ff == S_SETUP, "accepted command did not enter setup")
   `MPFD_ASSERT_NOW(a_walk_bounds, clock, reset, state_ff == S_WALK, (col_ff <= col_end_ff && page_ff <= page_end_ff), "walk left its clip window")
   `MPFD_ASSERT_NEXT(a_result_held, clock, reset, state_ff == S_FINISH && rsp_valid_ff && !rsp_bus.ready, state_ff == S_FINISH && rsp_valid_ff, "result dropped while output word was stalled")

endmodule

`default_nettype wire

@@ rtl/mpfd_ram.sv @@
// Generic single-clock RAM: one write port and one read port with registered read data.
// No dependencies.
`default_nettype none

module mpfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sim/mono_page_framebuffer_draw_tb.sv @@
// Self-checking testbench for the monochrome page framebuffer draw engine.
// Depends on mpfd_pkg, the mpfd_req_if and mpfd_rsp_if channels and the top level.
// Expected results come from a behavioral framebuffer copy here or from typed rows.
`default_nettype none

module mono_page_framebuffer_draw_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ClockPeriod  = 20;
   localparam int ResetCycles  = 11;
   localparam int ScreenW      = 128;
   localparam int ScreenH      = 64;
   localparam int RandomItems  = 1000;
   localparam int DrainCycles  = 40;
   localparam int StallLimit   = 20000;
   localparam int HoldCycles   = 400;
   localparam int HoldAfter    = 150;

   // Command and paint codes that the block accepts but does not define.
   localparam logic [2:0] CmdSpareLo = 3'd6;
   localparam logic [2:0] CmdSpareHi = 3'd7;
   localparam logic [1:0] ModeSpare  = 2'd3;

   typedef struct {
      logic [2:0]         cmd;
      logic signed [10:0] x_pos;
      logic signed [10:0] y_pos;
      logic [7:0]         box_width;
      logic [7:0]         box_height;
      logic [1:0]         paint_mode;
      logic [9:0]         byte_index;
   } draw_cmd_type;

   typedef struct {
      logic       pixel_value;
      logic [7:0] byte_value;
   } readback_type;

   typedef struct {
      draw_cmd_type word;
      bit           typed;
      logic         pixel_value;
      logic [7:0]   byte_value;
   } table_row_type;

   logic clock = 1'b0;
   logic reset;

   mpfd_req_if req_ch ();
   mpfd_rsp_if rsp_ch ();

   mono_page_framebuffer_draw #(
      .SCREEN_W(ScreenW),
      .SCREEN_H(ScreenH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_ch),
      .rsp_bus(rsp_ch)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   logic [7:0]    frame_bytes [mpfd_pkg::StoreDepth];
   readback_type  awaited_results [$];
   table_row_type directed_rows [$];
   int            mismatches = 0;
   int            stalled_cycles = 0;
   int            sender_idle_pct = 27;
   int            receiver_idle_pct = 57;

   function automatic bit pixel_addr(input int x, input int y, output int addr);
      if (x < 0 || x >= ScreenW || y < 0 || y >= ScreenH) return 1'b0;
      addr = (y / mpfd_pkg::PageRows) * ScreenW + x;
      return addr < mpfd_pkg::StoreDepth;
   endfunction

   function automatic void paint_pixel(input int x, input int y, input logic [1:0] mode);
      int         addr;
      logic [7:0] bit_mask;
      if (!pixel_addr(x, y, addr)) return;
      bit_mask = 8'b1 << (y % mpfd_pkg::PageRows);
      case (mode)
         mpfd_pkg::ModeInvert: frame_bytes[addr] = frame_bytes[addr] ^ bit_mask;
         mpfd_pkg::ModeClear:  frame_bytes[addr] = frame_bytes[addr] & ~bit_mask;
         default:              frame_bytes[addr] = frame_bytes[addr] | bit_mask;
      endcase
   endfunction

   // Inclusive span of columns and rows; nothing is painted when a span is reversed.
   function automatic void paint_run(input int x0, input int x1, input int y0, input int y1,
                                     input logic [1:0] mode);
      for (int x = x0; x <= x1; x++)
         for (int y = y0; y <= y1; y++)
            paint_pixel(x, y, mode);
   endfunction

   function automatic readback_type predict_draw(input draw_cmd_type c);
      readback_type r;
      int           x, y, w, h, addr;
      bit           corner;
      r.pixel_value = 1'b0;
      r.byte_value  = 8'h00;
      x = c.x_pos;
      y = c.y_pos;
      w = c.box_width;
      h = c.box_height;
      case (c.cmd)
         mpfd_pkg::CmdPlot: paint_pixel(x, y, c.paint_mode);
         mpfd_pkg::CmdReadPix: begin
            if (pixel_addr(x, y, addr))
               r.pixel_value = frame_bytes[addr][y % mpfd_pkg::PageRows];
         end
         mpfd_pkg::CmdFill, mpfd_pkg::CmdRoundFill: begin
            for (int o = 0; o < w; o++) begin
               for (int p = 0; p < h; p++) begin
                  corner = (o == 0 || o == w - 1) && (p == 0 || p == h - 1);
                  if (!(c.cmd == mpfd_pkg::CmdRoundFill && corner))
                     paint_pixel(x + o, y + p, c.paint_mode);
               end
            end
         end
         mpfd_pkg::CmdFrame: begin
            if (w != 0 && h != 0) begin
               paint_run(x + 1, x + w - 2, y, y, c.paint_mode);
               paint_run(x + 1, x + w - 2, y + h - 1, y + h - 1, c.paint_mode);
               paint_run(x, x, y + 1, y + h - 2, c.paint_mode);
               paint_run(x + w - 1, x + w - 1, y + 1, y + h - 2, c.paint_mode);
            end
         end
         mpfd_pkg::CmdReadByte: r.byte_value = frame_bytes[c.byte_index];
         default: ;
      endcase
      return r;
   endfunction

   function automatic void add_row(input logic [2:0] cmd, input int x, input int y,
                                   input int w, input int h, input logic [1:0] mode,
                                   input int idx, input bit typed, input logic pix,
                                   input logic [7:0] byt);
      table_row_type r;
      r.word.cmd        = cmd;
      r.word.x_pos      = x[10:0];
      r.word.y_pos      = y[10:0];
      r.word.box_width  = w[7:0];
      r.word.box_height = h[7:0];
      r.word.paint_mode = mode;
      r.word.byte_index = idx[9:0];
      r.typed           = typed;
      r.pixel_value     = pix;
      r.byte_value      = byt;
      directed_rows.push_back(r);
   endfunction

   // Mostly near-screen coordinates and small shapes, with the full ranges mixed in.
   function automatic draw_cmd_type random_word();
      draw_cmd_type c;
      int           pick, xv, yv;
      pick = $urandom_range(99);
      if (pick < 18)      c.cmd = mpfd_pkg::CmdPlot;
      else if (pick < 36) c.cmd = mpfd_pkg::CmdReadPix;
      else if (pick < 50) c.cmd = mpfd_pkg::CmdFill;
      else if (pick < 60) c.cmd = mpfd_pkg::CmdRoundFill;
      else if (pick < 70) c.cmd = mpfd_pkg::CmdFrame;
      else if (pick < 95) c.cmd = mpfd_pkg::CmdReadByte;
      else                c.cmd = $urandom_range(1) ? CmdSpareHi : CmdSpareLo;
      if ($urandom_range(99) < 85) xv = $urandom_range(ScreenW + 31) - 16;
      else                         xv = $urandom_range(2047);
      if ($urandom_range(99) < 85) yv = $urandom_range(ScreenH + 31) - 16;
      else                         yv = $urandom_range(2047);
      c.x_pos = xv[10:0];
      c.y_pos = yv[10:0];
      c.box_width  = ($urandom_range(99) < 90) ? 8'($urandom_range(24)) :
                                                 8'($urandom_range(255));
      c.box_height = ($urandom_range(99) < 90) ? 8'($urandom_range(24)) :
                                                 8'($urandom_range(255));
      pick = $urandom_range(9);
      if (pick < 3)      c.paint_mode = mpfd_pkg::ModeSet;
      else if (pick < 6) c.paint_mode = mpfd_pkg::ModeClear;
      else if (pick < 9) c.paint_mode = mpfd_pkg::ModeInvert;
      else               c.paint_mode = ModeSpare;
      c.byte_index = 10'($urandom_range(mpfd_pkg::StoreDepth - 1));
      return c;
   endfunction

   // Offers one command word and records its expected result once it is taken.
   task automatic issue(input draw_cmd_type c, input bit typed, input logic pix,
                        input logic [7:0] byt);
      readback_type guess;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= c.cmd;
      req_ch.x_pos      <= c.x_pos;
      req_ch.y_pos      <= c.y_pos;
      req_ch.box_width  <= c.box_width;
      req_ch.box_height <= c.box_height;
      req_ch.paint_mode <= c.paint_mode;
      req_ch.byte_index <= c.byte_index;
      do @(posedge clock); while (!req_ch.ready);
      guess = predict_draw(c);
      if (typed) begin
         guess.pixel_value = pix;
         guess.byte_value  = byt;
      end
      awaited_results.push_back(guess);
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= mpfd_pkg::CmdPlot;
      req_ch.x_pos      <= '0;
      req_ch.y_pos      <= '0;
      req_ch.box_width  <= '0;
      req_ch.box_height <= '0;
      req_ch.paint_mode <= mpfd_pkg::ModeSet;
      req_ch.byte_index <= '0;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;

      add_row(mpfd_pkg::CmdReadByte, 0, 0, 0, 0, mpfd_pkg::ModeSet, 0, 1, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdReadPix, 0, 0, 0, 0, mpfd_pkg::ModeSet, 0, 1, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdPlot, 0, 0, 0, 0, mpfd_pkg::ModeSet, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdReadByte, 0, 0, 0, 0, mpfd_pkg::ModeSet, 0, 1, 1'b0, 8'h01);
      add_row(mpfd_pkg::CmdPlot, ScreenW - 1, ScreenH - 1, 255, 255, mpfd_pkg::ModeSet,
              1023, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdReadByte, 0, 0, 0, 0, mpfd_pkg::ModeSet, 1023, 1, 1'b0, 8'h80);
      add_row(mpfd_pkg::CmdPlot, -1024, 1023, 0, 0, mpfd_pkg::ModeSet, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdReadPix, -1, 0, 0, 0, mpfd_pkg::ModeSet, 0, 1, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdReadPix, 1023, -1024, 0, 0, mpfd_pkg::ModeSet, 0, 1, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdPlot, 0, 0, 0, 0, mpfd_pkg::ModeClear, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdReadPix, 0, 0, 0, 0, mpfd_pkg::ModeSet, 0, 1, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdPlot, 5, 5, 0, 0, ModeSpare, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdReadPix, 5, 5, 0, 0, mpfd_pkg::ModeSet, 0, 1, 1'b1, 8'h00);
      add_row(mpfd_pkg::CmdFill, -4, -4, 255, 255, mpfd_pkg::ModeInvert, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdFill, 20, 20, 0, 10, mpfd_pkg::ModeSet, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdRoundFill, 10, 10, 8, 8, mpfd_pkg::ModeClear, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdRoundFill, 30, 30, 1, 1, mpfd_pkg::ModeClear, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdFrame, 2, 3, 20, 12, mpfd_pkg::ModeInvert, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdFrame, 40, 8, 0, 5, mpfd_pkg::ModeInvert, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdFrame, 50, 9, 1, 1, mpfd_pkg::ModeInvert, 0, 0, 1'b0, 8'h00);
      add_row(CmdSpareLo, 7, 7, 9, 9, mpfd_pkg::ModeSet, 5, 1, 1'b0, 8'h00);
      add_row(CmdSpareHi, -1, -1, 255, 255, ModeSpare, 1023, 1, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdReadByte, 0, 0, 0, 0, mpfd_pkg::ModeSet, 1023, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdFill, 0, 0, 255, 255, mpfd_pkg::ModeClear, 0, 0, 1'b0, 8'h00);
      add_row(mpfd_pkg::CmdReadByte, 0, 0, 0, 0, mpfd_pkg::ModeSet, 512, 1, 1'b0, 8'h00);

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].pixel_value,
               directed_rows[i].byte_value);

      for (int n = 0; n < RandomItems; n++) begin
         if (n == RandomItems / 3) begin
            sender_idle_pct   = 57;
            receiver_idle_pct = 27;
         end else if (n == 2 * RandomItems / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         issue(random_word(), 1'b0, 1'b0, 8'h00);
      end
      req_ch.valid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("mono_page_framebuffer_draw_tb passed");
      end else begin
         $display("mono_page_framebuffer_draw_tb failed");
      end
      $finish;
   end

   // Result side: random stalls, plus one long hold-off so that the engine backs up.
   initial begin
      int hold_left;
      int results_seen;
      bit hold_done;
      hold_left    = 0;
      results_seen = 0;
      hold_done    = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) results_seen++;
         if (!hold_done && results_seen >= HoldAfter) begin
            hold_left = HoldCycles;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_result
      readback_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result word, pixel_value %0d, byte_value %02h",
                     $time, rsp_ch.pixel_value, rsp_ch.byte_value);
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_ch.pixel_value !== want.pixel_value) begin
               $display("%0t: pixel_value expected %0d, actual %0d",
                        $time, want.pixel_value, rsp_ch.pixel_value);
               mismatches++;
            end
            if (rsp_ch.byte_value !== want.byte_value) begin
               $display("%0t: byte_value expected %02h, actual %02h",
                        $time, want.byte_value, rsp_ch.byte_value);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= StallLimit) begin
         $display("%0t: no word moved for %0d cycles", $time, stalled_cycles);
         $display("mono_page_framebuffer_draw_tb failed");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

endmodule

`default_nettype wire
